>>> design/causal_delivery_holdback_core_defines.svh
// Assertion macros used by the checker file cdh_checker.sv.
`ifndef CAUSAL_DELIVERY_HOLDBACK_CORE_DEFINES_SVH
`define CAUSAL_DELIVERY_HOLDBACK_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CDH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("causal delivery check failed");

// Next-cycle implication, checked while out of reset.
`define CDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("causal delivery check failed");

`endif

>>> design/cdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdh_pkg;

  localparam int NumNodesDef   = 4;
  localparam int HoldDepthDef  = 8;
  localparam int ClockWidthDef = 16;
  localparam int MaxOut        = 8;
  localparam int StampEntryW   = 16;

  localparam logic [1:0] RK_SEND    = 2'd0;
  localparam logic [1:0] RK_DELIVER = 2'd1;
  localparam logic [1:0] RK_DROP    = 2'd2;

  localparam logic KIND_SEND    = 1'b0;
  localparam logic KIND_ARRIVAL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [1:0]  sender;
    logic [63:0] stamp;
    logic [7:0]  tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  from_node;
    logic [7:0]  tag_out;
    logic [63:0] stamp_out;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0]  sender;
    logic [63:0] stamp;
    logic [7:0]  tag;
  } entry_t;

  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_NEXT = 2'd1,
    SEL_HEAD = 2'd2,
    SEL_IN   = 2'd3
  } cell_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

endpackage
`default_nettype wire

>>> design/causal_delivery_holdback_core.sv
// A local send or a dropped arrival is staged in the pending register and, once the
// output is free, moved to the output register in the finish state. An arrival fills
// a free hold-back cell; repeated scan passes deliver or rotate each held entry.
// One item is worked on at a time; the rotating cell chain sets the throughput.
// Reset (asynchronous, active low) clears the clock vector, fill count, own_id and control.
`timescale 1ns / 1ps
`default_nettype none
module causal_delivery_holdback_core #(
  parameter int NUM_NODES   = cdh_pkg::NumNodesDef,
  parameter int HOLD_DEPTH  = cdh_pkg::HoldDepthDef,
  parameter int CLOCK_WIDTH = cdh_pkg::ClockWidthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cdh_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cdh_pkg::out_t      out_data_o
);

  localparam int CntW = $clog2(HOLD_DEPTH + 1);
  localparam int NW   = $clog2(cdh_pkg::MaxOut + 1);
  localparam logic [CLOCK_WIDTH-1:0] ClockMax = '1;

  cdh_pkg::state_e state_q, state_d;
  logic [1:0] own_id_q;
  logic [CLOCK_WIDTH-1:0] clock_q [NUM_NODES];
  logic [CLOCK_WIDTH-1:0] clock_d [NUM_NODES];
  logic [CntW-1:0] cnt_q, cnt_d, rem_q, rem_d;
  logic [NW-1:0] n_q, n_d;
  logic prog_q, prog_d;
  cdh_pkg::out_t pend_q, pend_d, out_q, out_d;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic bump_en;
  logic [1:0] bump_node;
  logic [63:0] send_stamp;
  logic dlv, out_free;

  cdh_pkg::entry_t cells [HOLD_DEPTH];
  cdh_pkg::cell_sel_e sel [HOLD_DEPTH];
  cdh_pkg::entry_t in_entry;

  assign in_entry = '{sender: in_data_i.sender, stamp: in_data_i.stamp, tag: in_data_i.tag};

  for (genvar k = 0; k < HOLD_DEPTH; k++) begin : g_cell
    cdh_pkg::entry_t nxt;
    if (k == HOLD_DEPTH - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cells[k+1];
    end
    cdh_cell u_cell (
      .clk_i (clk_i),
      .sel_i (sel[k]),
      .next_i(nxt),
      .head_i(cells[0]),
      .in_i  (in_entry),
      .q_o   (cells[k])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_NODES; i++) begin
      clock_d[i] = clock_q[i];
      if (bump_en && bump_node == 2'(i) && clock_q[i] != ClockMax) begin
        clock_d[i] = clock_q[i] + CLOCK_WIDTH'(1);
      end
    end
  end

  always_comb begin
    send_stamp = '0;
    for (int i = 0; i < NUM_NODES; i++) begin
      send_stamp[cdh_pkg::StampEntryW*i +: cdh_pkg::StampEntryW] =
        cdh_pkg::StampEntryW'(clock_d[i]);
    end
  end

  always_comb begin
    logic ok;
    logic sok;
    logic [cdh_pkg::StampEntryW-1:0] e;
    ok  = 1'b1;
    sok = 1'b0;
    e   = '0;
    for (int i = 0; i < NUM_NODES; i++) begin
      e = cells[0].stamp[cdh_pkg::StampEntryW*i +: cdh_pkg::StampEntryW];
      if (cells[0].sender == 2'(i)) begin
        sok = 1'b1;
        if ({1'b0, e} != (17'(clock_q[i]) + 17'd1)) begin
          ok = 1'b0;
        end
      end else if (e > cdh_pkg::StampEntryW'(clock_q[i])) begin
        ok = 1'b0;
      end
    end
    dlv = (cells[0].sender == own_id_q) || (ok && sok);
  end

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    n_d       = n_q;
    prog_d    = prog_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q;
    bump_en   = 1'b0;
    bump_node = own_id_q;
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      sel[k] = cdh_pkg::SEL_HOLD;
    end
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    unique case (state_q)
      cdh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == cdh_pkg::KIND_SEND) begin
            bump_en  = 1'b1;
            pend_d   = '{cdh_pkg::RK_SEND, own_id_q, in_data_i.tag, send_stamp, 1'b1};
            pend_v_d = 1'b1;
            state_d  = cdh_pkg::ST_FINISH;
          end else if (cnt_q == CntW'(HOLD_DEPTH)) begin
            pend_d   = '{cdh_pkg::RK_DROP, in_data_i.sender, in_data_i.tag, 64'd0, 1'b1};
            pend_v_d = 1'b1;
            state_d  = cdh_pkg::ST_FINISH;
          end else begin
            for (int k = 0; k < HOLD_DEPTH; k++) begin
              if (cnt_q == CntW'(k)) begin
                sel[k] = cdh_pkg::SEL_IN;
              end
            end
            cnt_d   = cnt_q + CntW'(1);
            rem_d   = cnt_q + CntW'(1);
            n_d     = '0;
            prog_d  = 1'b0;
            state_d = cdh_pkg::ST_SCAN;
          end
        end
      end
      cdh_pkg::ST_SCAN: begin
        if (!(pend_v_q && !out_free)) begin
          if (rem_q == '0) begin
            if (prog_q && n_q < NW'(cdh_pkg::MaxOut)) begin
              rem_d  = cnt_q;
              prog_d = 1'b0;
            end else begin
              state_d = cdh_pkg::ST_FINISH;
            end
          end else if (dlv) begin
            for (int k = 0; k < HOLD_DEPTH; k++) begin
              sel[k] = cdh_pkg::SEL_NEXT;
            end
            cnt_d  = cnt_q - CntW'(1);
            rem_d  = rem_q - CntW'(1);
            n_d    = n_q + NW'(1);
            prog_d = 1'b1;
            if (cells[0].sender != own_id_q) begin
              bump_en   = 1'b1;
              bump_node = cells[0].sender;
            end
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
            pend_d   = '{cdh_pkg::RK_DELIVER, cells[0].sender, cells[0].tag, 64'd0, 1'b0};
            pend_v_d = 1'b1;
            if (n_q + NW'(1) == NW'(cdh_pkg::MaxOut)) begin
              state_d = cdh_pkg::ST_FLUSH;
            end
          end else begin
            for (int k = 0; k < HOLD_DEPTH; k++) begin
              if (k < int'(cnt_q) - 1) begin
                sel[k] = cdh_pkg::SEL_NEXT;
              end else if (k == int'(cnt_q) - 1) begin
                sel[k] = cdh_pkg::SEL_HEAD;
              end
            end
            rem_d = rem_q - CntW'(1);
          end
        end
      end
      cdh_pkg::ST_FLUSH: begin
        if (rem_q == '0) begin
          state_d = cdh_pkg::ST_FINISH;
        end else begin
          for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (k < int'(cnt_q) - 1) begin
              sel[k] = cdh_pkg::SEL_NEXT;
            end else if (k == int'(cnt_q) - 1) begin
              sel[k] = cdh_pkg::SEL_HEAD;
            end
          end
          rem_d = rem_q - CntW'(1);
        end
      end
      cdh_pkg::ST_FINISH: begin
        if (pend_v_q) begin
          if (out_free) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
            out_v_d    = 1'b1;
            pend_v_d   = 1'b0;
            state_d    = cdh_pkg::ST_IDLE;
          end
        end else begin
          state_d = cdh_pkg::ST_IDLE;
        end
      end
      default: state_d = cdh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cdh_pkg::ST_IDLE;
      own_id_q <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      n_q      <= '0;
      prog_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < NUM_NODES; i++) begin
        clock_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      n_q      <= n_d;
      prog_q   <= prog_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      for (int i = 0; i < NUM_NODES; i++) begin
        clock_q[i] <= clock_d[i];
      end
      if (cfg_valid_i) begin
        own_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == cdh_pkg::ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> design/cdh_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cdh_cell (
  input  wire logic              clk_i,
  input  wire cdh_pkg::cell_sel_e sel_i,
  input  wire cdh_pkg::entry_t   next_i,
  input  wire cdh_pkg::entry_t   head_i,
  input  wire cdh_pkg::entry_t   in_i,
  output cdh_pkg::entry_t        q_o
);

  cdh_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    unique case (sel_i)
      cdh_pkg::SEL_NEXT: entry_q <= next_i;
      cdh_pkg::SEL_HEAD: entry_q <= head_i;
      cdh_pkg::SEL_IN:   entry_q <= in_i;
      default:           entry_q <= entry_q;
    endcase
  end

  assign q_o = entry_q;

endmodule
`default_nettype wire

>>> design/cdh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "causal_delivery_holdback_core_defines.svh"
module cdh_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire cdh_pkg::out_t out_data_o
);

  `CDH_ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  `CDH_ASSERT_NEXT(a_out_held, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `CDH_ASSERT_NOW(a_send_single, out_valid_o && out_data_o.result_kind != cdh_pkg::RK_DELIVER, out_data_o.last)
  `CDH_ASSERT_NOW(a_deliver_no_stamp, out_valid_o && out_data_o.result_kind == cdh_pkg::RK_DELIVER, out_data_o.stamp_out == 64'd0)

endmodule

bind causal_delivery_holdback_core cdh_checker u_cdh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

>>> dv/causal_delivery_holdback_checker.sv
`timescale 1ns / 1ps
module causal_delivery_holdback_checker
  import cdh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_t       out_data_i,
  output int         mismatches_o,
  output int         outstanding_o
);

  logic [1:0]  node_id;
  logic [15:0] vclock [4];
  entry_t      holdback [$];
  out_t        due_q [$];
  int          errs;

  function automatic bit causally_ready(entry_t e);
    logic [15:0] v;
    if (e.sender == node_id) return 1'b1;
    for (int j = 0; j < 4; j++) begin
      v = e.stamp[16*j +: 16];
      if (j == e.sender) begin
        if ({1'b0, v} != {1'b0, vclock[j]} + 17'd1) return 1'b0;
      end else if (v > vclock[j]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic tick_clock(logic [1:0] n);
    if (vclock[n] != 16'hFFFF) vclock[n] = vclock[n] + 16'd1;
  endtask

  task automatic absorb_item(in_t it);
    out_t   r;
    entry_t e;
    int     n;
    int     i;
    bit     moved;
    n = 0;
    if (it.kind == KIND_SEND) begin
      tick_clock(node_id);
      r = '{RK_SEND, node_id, it.tag, {vclock[3], vclock[2], vclock[1], vclock[0]}, 1'b1};
      due_q.push_back(r);
    end else if (holdback.size() >= 8) begin
      r = '{RK_DROP, it.sender, it.tag, 64'd0, 1'b1};
      due_q.push_back(r);
    end else begin
      e = '{it.sender, it.stamp, it.tag};
      holdback.push_back(e);
      do begin
        moved = 1'b0;
        i = 0;
        while (i < holdback.size() && n < MaxOut) begin
          if (causally_ready(holdback[i])) begin
            r = '{RK_DELIVER, holdback[i].sender, holdback[i].tag, 64'd0, 1'b0};
            due_q.push_back(r);
            n++;
            if (holdback[i].sender != node_id) tick_clock(holdback[i].sender);
            holdback.delete(i);
            moved = 1'b1;
          end else begin
            i++;
          end
        end
      end while (moved && n < MaxOut);
      if (n > 0) due_q[due_q.size()-1].last = 1'b1;
    end
  endtask

  task automatic match_result(out_t got);
    out_t w;
    if (due_q.size() == 0) begin
      $display("%0t: unexpected result, actual %h", $time, got);
      errs++;
      return;
    end
    w = due_q.pop_front();
    if (got.result_kind !== w.result_kind) begin
      $display("%0t: result_kind expected %0d actual %0d", $time, w.result_kind, got.result_kind);
      errs++;
    end
    if (got.from_node !== w.from_node) begin
      $display("%0t: from_node expected %0d actual %0d", $time, w.from_node, got.from_node);
      errs++;
    end
    if (got.tag_out !== w.tag_out) begin
      $display("%0t: tag_out expected %h actual %h", $time, w.tag_out, got.tag_out);
      errs++;
    end
    if (got.stamp_out !== w.stamp_out) begin
      $display("%0t: stamp_out expected %h actual %h", $time, w.stamp_out, got.stamp_out);
      errs++;
    end
    if (got.last !== w.last) begin
      $display("%0t: last expected %0d actual %0d", $time, w.last, got.last);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id = 2'd0;
      for (int j = 0; j < 4; j++) vclock[j] = 16'd0;
      holdback.delete();
      due_q.delete();
      errs = 0;
    end else begin
      if (out_valid_i && out_ready_i) match_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) node_id = cfg_data_i;
      if (in_valid_i && in_ready_i) absorb_item(in_data_i);
    end
    mismatches_o  <= errs;
    outstanding_o <= due_q.size();
  end

endmodule

>>> dv/causal_delivery_holdback_core_test.sv
`timescale 1ns / 1ps
module causal_delivery_holdback_core_test;
  import cdh_pkg::*;

  localparam int CycleLimit = 600000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  int         mismatches;
  int         outstanding;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         cycles = 0;

  logic [1:0] own;
  int         sent [4];
  in_t        backlog [$];
  int         skips;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  causal_delivery_holdback_core uut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  causal_delivery_holdback_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic put_item(in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_node(logic [1:0] id);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= id;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    own = id;
  endtask

  function automatic in_t mk(logic k, logic [1:0] s, logic [63:0] st, logic [7:0] t);
    in_t it;
    it.kind = k;
    it.sender = s;
    it.stamp = st;
    it.tag = t;
    return it;
  endfunction

  function automatic logic [63:0] vec(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  task automatic local_send();
    sent[own]++;
    put_item(mk(KIND_SEND, 2'($urandom_range(3)), {$urandom, $urandom}, 8'($urandom)));
  endtask

  task automatic queue_causal_msg();
    logic [1:0]  s;
    logic [63:0] st;
    do s = 2'($urandom_range(3)); while (s == own);
    sent[s]++;
    st = '0;
    for (int j = 0; j < 4; j++)
      st[16*j +: 16] = (j == s) ? 16'(sent[j]) : 16'($urandom_range(sent[j]));
    backlog.push_back(mk(KIND_ARRIVAL, s, st, 8'($urandom)));
  endtask

  task automatic release_one();
    int k;
    k = (skips >= 3) ? 0 : $urandom_range(backlog.size() - 1);
    skips = (k == 0) ? 0 : skips + 1;
    put_item(backlog[k]);
    backlog.delete(k);
  endtask

  task automatic run_phase(logic [1:0] id, int idle, int stall, int count);
    int r;
    set_node(id);
    idle_pct  = idle;
    stall_pct = stall;
    skips = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 20) begin
        local_send();
      end else if (r < 30) begin
        put_item(mk(KIND_ARRIVAL, own, {$urandom, $urandom}, 8'($urandom)));
      end else begin
        queue_causal_msg();
        if (backlog.size() > 2) release_one();
      end
    end
    while (backlog.size() != 0) release_one();
  endtask

  initial begin
    own = 2'd0;
    for (int j = 0; j < 4; j++) sent[j] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_node(2'd0);
    put_item(mk(KIND_SEND, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00));
    put_item(mk(KIND_SEND, 2'd0, 64'd0, 8'hFF));
    put_item(mk(KIND_ARRIVAL, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
    put_item(mk(KIND_ARRIVAL, 2'd1, vec(2, 1, 0, 0), 8'h11));
    put_item(mk(KIND_ARRIVAL, 2'd2, vec(0, 1, 1, 1), 8'h22));
    put_item(mk(KIND_ARRIVAL, 2'd3, vec(0, 0, 0, 1), 8'h33));
    for (int k = 3; k <= 9; k++) put_item(mk(KIND_ARRIVAL, 2'd1, vec(0, k, 0, 0), 8'(k)));
    put_item(mk(KIND_ARRIVAL, 2'd1, vec(0, 2, 0, 0), 8'h02));
    sent[0] = 2;
    sent[1] = 9;
    sent[2] = 1;
    sent[3] = 1;

    run_phase(2'd3, 0, 0, 75);
    run_phase(2'd1, 88, 0, 75);
    run_phase(2'd2, 0, 88, 75);
    run_phase(2'($urandom_range(3)), 36, 36, 75);

    set_node(2'd3);
    for (int n = 0; n < 14; n++)
      put_item(mk(KIND_ARRIVAL, 2'($urandom_range(2)), {$urandom, $urandom}, 8'($urandom)));
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
